// File: rtl/spe_pkg.sv
// Shared types and constants of the scatterometer packet sample extractor.
// Used by the front, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps

package spe_pkg;

	// input field widths
	localparam int ID_W      = 11;
	localparam int LEN_W     = 16;
	localparam int BYTE_W    = 8;
	localparam int POS_W     = 16;

	// result field widths
	localparam int CHAN_OUT_W = 3;
	localparam int LINE_OUT_W = 14;
	localparam int COL_W      = 8;
	localparam int SAMPLE_W   = 16;
	localparam int WORD_W     = 16;

	// packet framing
	localparam logic [ID_W-1:0]  BASE_ID_RESET     = 11'd208;
	localparam logic [LEN_W-1:0] MIN_PAYLOAD       = 16'd654;
	localparam logic [POS_W-1:0] FIRST_SAMPLE_BYTE = 16'd140;
	localparam logic [POS_W-1:0] POS_MAX           = 16'hffff;

	// bfloat16 decode: value = (128 + f) * 2^(e - 134)
	localparam logic [7:0] EXP_ALL_ONES = 8'hff;
	localparam logic [7:0] EXP_UNIT     = 8'd134; // bias 127 plus 7 mantissa bits
	localparam logic [7:0] EXP_MIN_USED = 8'd127; // below: shifted out entirely
	localparam logic [7:0] EXP_SAT      = 8'd150; // at or above: saturates
	localparam int         MAG_W        = 23;     // 255 << 15 fits

	// floor(x / 100) = (x * ceil(2^30 / 100)) >> 30, exact for x < 2^23
	localparam int               RECIP_W     = 24;
	localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
	localparam int               RECIP_SHIFT = 30;
	localparam int               QUOT_W      = 17;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hffff;

	// work handed from front to back, channel travels beside it
	typedef struct packed {
		logic                 is_line_end;
		logic [COL_W-1:0]     column;
		logic [WORD_W-1:0]    word;
	} spe_cmd_t;

endpackage

// File: rtl/spe_front.sv
// Front end: holds the base id register, tracks the byte position in the packet,
// classifies each item and pushes result-producing work into the queue. Uses spe_pkg.
`timescale 1ns / 1ps

module spe_front #(
	parameter int SAMPLES_PER_LINE = 256,
	parameter int CHANNEL_COUNT    = 6,
	parameter int CH_W             = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [spe_pkg::ID_W-1:0]     cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [spe_pkg::ID_W-1:0]     packet_id,
	input  logic [spe_pkg::LEN_W-1:0]    payload_length,
	input  logic [spe_pkg::BYTE_W-1:0]   data_byte,
	input  logic                         final_byte,
	input  logic                         q_full,
	output logic                         push,
	output logic [CH_W-1:0]              push_ch,
	output spe_pkg::spe_cmd_t            push_cmd
);

	localparam logic [spe_pkg::POS_W-1:0] REGION_LEN = spe_pkg::POS_W'(2 * SAMPLES_PER_LINE);
	localparam logic [spe_pkg::ID_W-1:0]  CHAN_LIMIT = spe_pkg::ID_W'(CHANNEL_COUNT);

	logic [spe_pkg::ID_W-1:0]   base_q;
	logic [spe_pkg::POS_W-1:0]  pos_q;
	logic [spe_pkg::BYTE_W-1:0] held_q;

	logic                       accept;
	logic [spe_pkg::ID_W-1:0]   id_off;
	logic                       used;
	logic [spe_pkg::POS_W-1:0]  rel;
	logic                       in_region;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= spe_pkg::BASE_ID_RESET;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	// classify the item
	always_comb begin
		id_off    = packet_id - base_q;
		used      = (payload_length >= spe_pkg::MIN_PAYLOAD) && (packet_id >= base_q)
		            && (id_off < CHAN_LIMIT);
		rel       = pos_q - spe_pkg::FIRST_SAMPLE_BYTE;
		in_region = (pos_q >= spe_pkg::FIRST_SAMPLE_BYTE) && (rel < REGION_LEN) && rel[0];
	end

	assign push                 = accept && used && (final_byte || in_region);
	assign push_ch              = id_off[CH_W-1:0];
	assign push_cmd.is_line_end = final_byte;
	assign push_cmd.column      = final_byte ? '0 : rel[spe_pkg::COL_W:1];
	assign push_cmd.word        = {held_q, data_byte};

	// position and held byte update on every accepted item; position clears on the final byte and holds at its maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			held_q <= data_byte;
			if (final_byte) begin
				pos_q <= '0;
			end else if (pos_q != spe_pkg::POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/spe_queue.sv
// Short first-in first-out queue between front and back.
// Generic over entry width and depth; no package dependency.
`timescale 1ns / 1ps

module spe_queue #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;

	assign full     = (count_q == (AW+1)'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/spe_back.sv
// Back end: keeps the per-channel line counters, decodes the bfloat16 word,
// divides by 100 through a reciprocal multiply and holds the result register. Uses spe_pkg.
`timescale 1ns / 1ps

module spe_back #(
	parameter int MAX_LINES     = 16384,
	parameter int CHANNEL_COUNT = 6,
	parameter int CH_W          = 3,
	parameter int LINE_W        = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  logic [CH_W-1:0]                   q_ch,
	input  spe_pkg::spe_cmd_t                 q_cmd,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [spe_pkg::CHAN_OUT_W-1:0]    channel,
	output logic [spe_pkg::LINE_OUT_W-1:0]    line,
	output logic [spe_pkg::COL_W-1:0]         column,
	output logic [spe_pkg::SAMPLE_W-1:0]      sample_value,
	output logic                              is_line_end
);

	localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(MAX_LINES - 1);
	localparam int                PROD_W    = spe_pkg::MAG_W + spe_pkg::RECIP_W;

	logic [LINE_W-1:0] line_counts_q [CHANNEL_COUNT];

	// stage 1 registers
	logic                          v_s1;
	logic [CH_W-1:0]               ch_s1;
	logic [LINE_W-1:0]             line_s1;
	logic [spe_pkg::COL_W-1:0]     col_s1;
	logic [spe_pkg::MAG_W-1:0]     mag_s1;
	logic                          zero_s1;
	logic                          sat_s1;
	logic                          end_s1;

	// output register
	logic                          out_v_q;

	logic                          adv;
	logic [LINE_W-1:0]             ln;
	logic                          sign;
	logic [7:0]                    expo;
	logic [7:0]                    mant;
	logic [3:0]                    shamt;
	logic [spe_pkg::MAG_W-1:0]     mag;
	logic                          zero;
	logic                          sat;
	logic [PROD_W-1:0]             prod;
	logic [spe_pkg::QUOT_W-1:0]    quot;
	logic [spe_pkg::SAMPLE_W-1:0]  sample;

	assign adv   = !out_v_q || out_ready;
	assign q_pop = q_valid && (!v_s1 || adv);
	assign ln    = line_counts_q[q_ch];

	// split the word and align the mantissa to an integer
	always_comb begin
		sign  = q_cmd.word[15];
		expo  = q_cmd.word[14:7];
		mant  = {1'b1, q_cmd.word[6:0]};
		zero  = sign || (expo == spe_pkg::EXP_ALL_ONES) || (expo < spe_pkg::EXP_MIN_USED);
		sat   = !zero && (expo >= spe_pkg::EXP_SAT);
		if (expo >= spe_pkg::EXP_UNIT) begin
			shamt = 4'(expo - spe_pkg::EXP_UNIT);
			mag   = spe_pkg::MAG_W'(mant) << shamt;
		end else begin
			shamt = 4'(spe_pkg::EXP_UNIT - expo);
			mag   = spe_pkg::MAG_W'(mant >> shamt);
		end
	end

	// line counters advance on each line end, holding at the last line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				line_counts_q[i] <= '0;
			end
		end else if (q_pop && q_cmd.is_line_end && (ln < LINE_LAST)) begin
			line_counts_q[q_ch] <= ln + 1'b1;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (q_pop) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ch_s1   <= q_ch;
			line_s1 <= ln;
			col_s1  <= q_cmd.column;
			mag_s1  <= mag;
			zero_s1 <= zero;
			sat_s1  <= sat;
			end_s1  <= q_cmd.is_line_end;
		end
	end

	// divide by 100 and clamp; line ends and zeroed words give 0
	always_comb begin
		prod = PROD_W'(mag_s1) * PROD_W'(spe_pkg::RECIP_100);
		quot = prod[spe_pkg::RECIP_SHIFT +: spe_pkg::QUOT_W];
		if (end_s1 || zero_s1) begin
			sample = '0;
		end else if (sat_s1 || quot[spe_pkg::QUOT_W-1]) begin
			sample = spe_pkg::SAMPLE_MAX;
		end else begin
			sample = quot[spe_pkg::SAMPLE_W-1:0];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			channel      <= spe_pkg::CHAN_OUT_W'(ch_s1);
			line         <= spe_pkg::LINE_OUT_W'(line_s1);
			column       <= col_s1;
			sample_value <= sample;
			is_line_end  <= end_s1;
		end
	end

	assign out_valid = out_v_q;

endmodule

// File: rtl/scatterometer_packet_sample_extractor.sv
// Top level of the scatterometer packet sample extractor.
// Instantiates spe_front, spe_queue and spe_back; uses spe_pkg.
`timescale 1ns / 1ps

// Takes one payload byte per cycle while the queue is not full and sustains one
// item per cycle on both sides while m_tready is high. Packets of at least 654
// bytes whose id lies in base..base+CHANNEL_COUNT-1 give one sample result per
// 16-bit word in bytes 140 to 140+2*SAMPLES_PER_LINE-1 and one line-end result
// (tuser high) on their final byte; other bytes give nothing. A result passes
// through the four-entry queue, whose head is decoded into the stage register,
// and then through the divide-by-100 multiplier into the output register. The
// queue lets input keep flowing while the output is stalled, until it is full.
module scatterometer_packet_sample_extractor #(
	parameter int MAX_LINES        = 16384,
	parameter int SAMPLES_PER_LINE = 256,
	parameter int CHANNEL_COUNT    = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,     // base_packet_id
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,       // packet_id[10:0], payload_length[26:11], data_byte[34:27]
	input  logic        s_tlast,       // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,       // channel[2:0], line[16:3], column[24:17],
	                                   // sample_value[40:25]
	output logic        m_tuser        // is_line_end
);

	localparam int CH_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int LINE_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int Q_DEPTH = 4;
	localparam int Q_W     = CH_W + $bits(spe_pkg::spe_cmd_t);

	logic                      push;
	logic [CH_W-1:0]           push_ch;
	spe_pkg::spe_cmd_t         push_cmd;
	logic                      q_full;
	logic                      q_valid;
	logic                      q_pop;
	logic [Q_W-1:0]            q_data;
	logic [CH_W-1:0]           q_ch;
	spe_pkg::spe_cmd_t         q_cmd;

	logic [spe_pkg::CHAN_OUT_W-1:0] channel;
	logic [spe_pkg::LINE_OUT_W-1:0] line;
	logic [spe_pkg::COL_W-1:0]      column;
	logic [spe_pkg::SAMPLE_W-1:0]   sample_value;

	// accept and classify
	spe_front #(
		.SAMPLES_PER_LINE (SAMPLES_PER_LINE),
		.CHANNEL_COUNT    (CHANNEL_COUNT),
		.CH_W             (CH_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.packet_id      (s_tdata[10:0]),
		.payload_length (s_tdata[26:11]),
		.data_byte      (s_tdata[34:27]),
		.final_byte     (s_tlast),
		.q_full         (q_full),
		.push           (push),
		.push_ch        (push_ch),
		.push_cmd       (push_cmd)
	);

	// decoupling queue
	spe_queue #(
		.WIDTH (Q_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_ch, push_cmd}),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	assign q_ch  = q_data[Q_W-1 -: CH_W];
	assign q_cmd = q_data[$bits(spe_pkg::spe_cmd_t)-1:0];

	// decode, divide and deliver
	spe_back #(
		.MAX_LINES     (MAX_LINES),
		.CHANNEL_COUNT (CHANNEL_COUNT),
		.CH_W          (CH_W),
		.LINE_W        (LINE_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ch         (q_ch),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.channel      (channel),
		.line         (line),
		.column       (column),
		.sample_value (sample_value),
		.is_line_end  (m_tuser)
	);

	assign m_tdata = {7'b0, sample_value, column, line, channel};

endmodule
